// File: sv/spd_pkg.sv
// Package: shared types and constants for the speed packet deframer.
package spd_pkg;

  localparam int PacketBytes = 8;
  localparam int PosW        = $clog2(PacketBytes);
  localparam int DistW       = 23;
  localparam int DivBits     = DistW;
  localparam int CntW        = $clog2(DivBits);
  localparam int CfgW        = 16;
  localparam int IdxW        = 2;

  localparam logic [PosW-1:0]  LastPos   = PosW'(PacketBytes - 1);
  localparam logic [15:0]      PeriodMin = 16'd20;
  localparam logic [DistW-1:0] CmScale   = DistW'(100);
  localparam logic [CntW-1:0]  LastStep  = CntW'(DivBits - 1);

  typedef enum logic [IdxW-1:0] {
    RegHeader  = 2'd0,
    RegStopped = 2'd1,
    RegWheel   = 2'd2,
    RegRate    = 2'd3
  } spd_reg_e;

  typedef enum logic [2:0] {
    StIdle,
    StCheck,
    StPrep,
    StDiv1,
    StLoad2,
    StDiv2,
    StFinish
  } spd_state_e;

  typedef struct packed {
    logic store;
    logic capture;
    logic div_load1;
    logic div_load2;
    logic div_zero;
    logic div_step;
    logic out_load;
  } spd_cmd_t;

  typedef struct packed {
    logic pkt_ok;
    logic dist_zero;
  } spd_sts_t;

endpackage

// File: sv/spd_ctrl.sv
// Controller: sequences byte intake, packet check, two divisions and result handoff.
module spd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  spd_pkg::spd_sts_t sts_i,
  output spd_pkg::spd_cmd_t cmd_o
);
  import spd_pkg::*;

  spd_state_e    state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic          out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.store = 1'b1;
          state_d     = StCheck;
        end
      end
      StCheck: begin
        if (sts_i.pkt_ok) begin
          cmd_o.capture = 1'b1;
          state_d       = StPrep;
        end else begin
          state_d = StIdle;
        end
      end
      StPrep: begin
        cnt_d = '0;
        if (sts_i.dist_zero) begin
          cmd_o.div_zero = 1'b1;
          state_d        = StFinish;
        end else begin
          cmd_o.div_load1 = 1'b1;
          state_d         = StDiv1;
        end
      end
      StDiv1: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == LastStep) begin
          cnt_d   = '0;
          state_d = StLoad2;
        end
      end
      StLoad2: begin
        cmd_o.div_load2 = 1'b1;
        state_d         = StDiv2;
      end
      StDiv2: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == LastStep) begin
          cnt_d   = '0;
          state_d = StFinish;
        end
      end
      StFinish: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = StIdle;
        end
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten while still pending");
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_step |-> (cnt_q <= LastStep))
    else $error("divider step count out of range");
  a_accept_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == StCheck))
    else $error("accepted word not checked next cycle");
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv2 && cnt_q == LastStep) |=> (state_q == StFinish))
    else $error("second division did not finish");
`endif

endmodule

// File: sv/spd_dp.sv
// Datapath: config registers, packet buffer, checksum, period filter, shared divider.
module spd_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [spd_pkg::IdxW-1:0]  cfg_idx_i,
  input  logic [spd_pkg::CfgW-1:0]  cfg_data_i,
  input  logic [7:0]                rx_byte_i,
  input  spd_pkg::spd_cmd_t         cmd_i,
  output spd_pkg::spd_sts_t         sts_o,
  output logic [7:0]                status_byte_o,
  output logic [7:0]                spare_byte_o,
  output logic [15:0]               motor_current_o,
  output logic [15:0]               period_ms_o,
  output logic                      period_accepted_o,
  output logic [spd_pkg::DistW-1:0] distance_cm_o
);
  import spd_pkg::*;

  logic [7:0]       header_q;
  logic [15:0]      stopped_q;
  logic [15:0]      wheel_q;
  logic [7:0]       rate_q;

  logic [7:0]       buf_q [PacketBytes];
  logic [PosW-1:0]  pos_q, pos_d;
  logic [15:0]      kept_q, kept_d;

  logic [7:0]       cap_status_q, cap_spare_q;
  logic [15:0]      cap_current_q, cap_period_q;
  logic             cap_acc_q;

  logic [15:0]      rem_q, rem_d;
  logic [DistW-1:0] quo_q, quo_d;
  logic [15:0]      div_q, div_d;

  logic [7:0]       xsum;
  logic [15:0]      new_period;
  logic             accepted;
  logic [16:0]      trial;
  logic             ge;
  logic [7:0]       rate_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q  <= 8'd0;
      stopped_q <= 16'hFFFF;
      wheel_q   <= 16'd597;
      rate_q    <= 8'd1;
    end else if (cfg_we_i) begin
      unique case (spd_reg_e'(cfg_idx_i))
        RegHeader:  header_q  <= cfg_data_i[7:0];
        RegStopped: stopped_q <= cfg_data_i;
        RegWheel:   wheel_q   <= cfg_data_i;
        RegRate:    rate_q    <= cfg_data_i[7:0];
      endcase
    end
  end

  always_comb begin
    pos_d = pos_q;
    if (rx_byte_i == header_q) begin
      pos_d = '0;
    end else if (pos_q != LastPos) begin
      pos_d = pos_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      for (int i = 0; i < PacketBytes; i++) begin
        buf_q[i] <= 8'd0;
      end
    end else if (cmd_i.store) begin
      pos_q        <= pos_d;
      buf_q[pos_d] <= rx_byte_i;
    end
  end

  always_comb begin
    xsum = 8'd0;
    for (int i = 0; i < PacketBytes - 1; i++) begin
      xsum = xsum ^ buf_q[i];
    end
  end

  assign new_period      = {buf_q[5], buf_q[6]};
  assign accepted        = new_period > PeriodMin;
  assign kept_d          = accepted ? new_period : kept_q;
  assign sts_o.pkt_ok    = (pos_q == LastPos) && (xsum == buf_q[PacketBytes-1]);
  assign sts_o.dist_zero = (kept_q == 16'd0) || (kept_q == stopped_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kept_q <= 16'd0;
    end else if (cmd_i.capture) begin
      kept_q <= kept_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cap_status_q  <= buf_q[1];
      cap_spare_q   <= buf_q[2];
      cap_current_q <= {buf_q[3], buf_q[4]};
      cap_period_q  <= kept_d;
      cap_acc_q     <= accepted;
    end
  end

  // restoring divider, one quotient bit per step
  assign rate_eff = (rate_q == 8'd0) ? 8'd1 : rate_q;
  assign trial    = {rem_q, quo_q[DistW-1]};
  assign ge       = trial >= {1'b0, div_q};

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    div_d = div_q;
    if (cmd_i.div_load1) begin
      rem_d = '0;
      quo_d = DistW'(wheel_q) * CmScale;
      div_d = kept_q;
    end else if (cmd_i.div_load2) begin
      rem_d = '0;
      div_d = {8'd0, rate_eff};
    end else if (cmd_i.div_zero) begin
      quo_d = '0;
    end else if (cmd_i.div_step) begin
      rem_d = ge ? 16'(trial - {1'b0, div_q}) : trial[15:0];
      quo_d = {quo_q[DistW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_byte_o     <= cap_status_q;
      spare_byte_o      <= cap_spare_q;
      motor_current_o   <= cap_current_q;
      period_ms_o       <= cap_period_q;
      period_accepted_o <= cap_acc_q;
      distance_cm_o     <= quo_q;
    end
  end

endmodule

// File: sv/speed_packet_deframer_unit.sv
// Top level: speed packet deframer, controller plus datapath.
//
//  channel  signals                         direction  notes
//  in       in_valid_i/in_ready_o, rx_byte  input      one received byte per word
//  out      out_valid_o/out_ready_i, fields output     one word per good packet
//  cfg      cfg_we_i, cfg_idx_i, cfg_data_i input      write only, no wait
//
// A byte that completes no packet only passes the check state; a good packet goes through
// check, period update, two 23-step restoring divisions through one shared unit, and handoff.
// A zero or stopped period skips the divisions.
// Reset clears buffer, position, kept period and loads register defaults.
// A finished result waits in the output register while the next byte is taken.
module speed_packet_deframer_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [spd_pkg::IdxW-1:0]  cfg_idx_i,
  input  logic [spd_pkg::CfgW-1:0]  cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [7:0]                rx_byte_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [7:0]                status_byte_o,
  output logic [7:0]                spare_byte_o,
  output logic [15:0]               motor_current_o,
  output logic [15:0]               period_ms_o,
  output logic                      period_accepted_o,
  output logic [spd_pkg::DistW-1:0] distance_cm_o
);
  import spd_pkg::*;

  spd_cmd_t cmd;
  spd_sts_t sts;

  spd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  spd_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .rx_byte_i         (rx_byte_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .status_byte_o     (status_byte_o),
    .spare_byte_o      (spare_byte_o),
    .motor_current_o   (motor_current_o),
    .period_ms_o       (period_ms_o),
    .period_accepted_o (period_accepted_o),
    .distance_cm_o     (distance_cm_o)
  );

endmodule
